@@ rtl/buffer_pool_manager_top_assert.svh @@
// Assertion macros used by the buffer pool checker.
`ifndef BUFFER_POOL_MANAGER_TOP_ASSERT_SVH
`define BUFFER_POOL_MANAGER_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define BPM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BPM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/bpm_pkg.sv @@
package bpm_pkg;

   // Field widths
   localparam int FUNC_W  = 2;
   localparam int IDX_W   = 8;
   localparam int CNT_W   = 9;
   localparam int STAT_W  = 3;
   localparam int SCNT_W  = 16;
   localparam int CSR_IDX_W = 2;

   // Storage and defaults
   localparam int MAX_BUFFERS_DEFAULT = 256;
   localparam int LIST_DEPTH          = 256;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE = 2'd2;

   // Configuration reset values
   localparam logic [CNT_W-1:0] TARGET_RESET  = 9'd1;
   localparam logic [CNT_W-1:0] LIMIT_RESET   = 9'd256;
   localparam logic [CNT_W-1:0] RESERVE_RESET = 9'd0;

   // Request functions
   localparam logic [FUNC_W-1:0] FUNC_GET     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET_RES = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PUT     = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd3;

   // Response status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_REFUSED = 3'd1;
   localparam logic [STAT_W-1:0] STAT_WAIT    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOINIT  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_MISUSE  = 3'd4;

   // Source of a granted index
   localparam logic [1:0] SRC_NONE  = 2'd0;
   localparam logic [1:0] SRC_FIFO  = 2'd1;
   localparam logic [1:0] SRC_STACK = 2'd2;
   localparam logic [1:0] SRC_FRESH = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              no_wait;
      logic [IDX_W-1:0]  buffer_in;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [IDX_W-1:0]  buffer_out;
      logic [CNT_W-1:0]  owned_now;
      logic [CNT_W-1:0]  issued_now;
      logic [CNT_W-1:0]  cached_free;
      logic [SCNT_W-1:0] fresh_allocs;
      logic [SCNT_W-1:0] releases;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic fill_en;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic init_go;
      logic fill_last;
   } stat_type;

endpackage

@@ rtl/bpm_ram.sv @@
module bpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bpm_ctrl.sv @@
module bpm_ctrl import bpm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type dp_stat,
   output cmd_type  dp_cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FILL = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // Take a beat only when idle and the response slot is free or emptying
   assign req_stall = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   assign dp_cmd.accept   = accept;
   assign dp_cmd.fill_en  = (state_ff == ST_FILL);
   assign dp_cmd.load_rsp = (state_ff == ST_RESP);

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = dp_stat.init_go ? ST_FILL : ST_RESP;
            end
         end
         ST_FILL: begin
            if (dp_stat.fill_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response until it is taken
   always_comb begin
      if (dp_cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/bpm_dp.sv @@
module bpm_dp import bpm_pkg::*; #(
   parameter int MAX_BUFFERS = MAX_BUFFERS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata,
   input  req_type              req_data,
   output rsp_type              rsp_data,
   input  cmd_type              dp_cmd,
   output stat_type             dp_stat
);

   localparam logic [CNT_W-1:0] HEAP_SLOTS =
      CNT_W'((MAX_BUFFERS < LIST_DEPTH) ? MAX_BUFFERS : LIST_DEPTH);
   localparam int AW = $clog2(LIST_DEPTH);

   // Configuration
   logic [CNT_W-1:0] target_ff, limit_ff, reserve_ff;

   // Pool state
   logic [AW-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  depth_ff, depth_in;
   logic [CNT_W-1:0]  fresh_ff, fresh_in;
   logic [CNT_W-1:0]  owned_ff, owned_in;
   logic [CNT_W-1:0]  issued_ff, issued_in;
   logic [SCNT_W-1:0] allocs_ff, allocs_in;
   logic [SCNT_W-1:0] rels_ff, rels_in;
   logic              ready_ff, ready_in;
   logic [CNT_W-1:0]  fillcnt_ff, fillcnt_in;

   // Outcome of the accepted beat
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic [1:0]        src_ff, src_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   rsp_type           rsp_ff;

   // Memory ports
   logic             fifo_we, stack_we;
   logic [AW-1:0]    fifo_waddr;
   logic [IDX_W-1:0] fifo_wdata, fifo_rdata, stack_rdata;
   logic             put_fifo, put_stack;

   logic             init_bad;
   logic             is_res;
   logic             allowed;
   logic [CNT_W:0]   owned_plus_res;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= TARGET_RESET;
         limit_ff   <= LIMIT_RESET;
         reserve_ff <= RESERVE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TARGET:  target_ff  <= csr_wdata;
            CSR_LIMIT:   limit_ff   <= csr_wdata;
            CSR_RESERVE: reserve_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign init_bad = (target_ff == '0) || (target_ff > limit_ff) || (target_ff > HEAP_SLOTS);
   assign is_res   = (req_data.func == FUNC_GET_RES);
   assign owned_plus_res = {1'b0, owned_ff} + {1'b0, reserve_ff};
   assign allowed  = (owned_plus_res < {1'b0, limit_ff}) ||
                     (is_res && (owned_ff < limit_ff));

   assign dp_stat.init_go   = (req_data.func == FUNC_INIT) && !init_bad;
   assign dp_stat.fill_last = ((fillcnt_ff + CNT_W'(1)) == fill_ff);

   // Decide the beat and compute the next pool state
   always_comb begin
      head_in    = head_ff;
      fill_in    = fill_ff;
      depth_in   = depth_ff;
      fresh_in   = fresh_ff;
      owned_in   = owned_ff;
      issued_in  = issued_ff;
      allocs_in  = allocs_ff;
      rels_in    = rels_ff;
      ready_in   = ready_ff;
      fillcnt_in = dp_cmd.fill_en ? fillcnt_ff + CNT_W'(1) : fillcnt_ff;
      stat_in    = stat_ff;
      src_in     = src_ff;
      slot_in    = slot_ff;
      put_fifo   = 1'b0;
      put_stack  = 1'b0;
      if (dp_cmd.accept) begin
         stat_in = STAT_OK;
         src_in  = SRC_NONE;
         slot_in = '0;
         if (req_data.func == FUNC_INIT) begin
            if (init_bad) begin
               stat_in = STAT_MISUSE;
            end else begin
               head_in    = '0;
               fill_in    = target_ff;
               depth_in   = '0;
               fresh_in   = target_ff;
               owned_in   = target_ff;
               issued_in  = '0;
               allocs_in  = '0;
               rels_in    = '0;
               ready_in   = 1'b1;
               fillcnt_in = '0;
            end
         end else if (!ready_ff) begin
            stat_in = STAT_NOINIT;
         end else if (req_data.func == FUNC_PUT) begin
            if ((issued_ff == '0) || ({1'b0, req_data.buffer_in} >= HEAP_SLOTS)) begin
               stat_in = STAT_MISUSE;
            end else if ((owned_ff <= target_ff) && (fill_ff < CNT_W'(LIST_DEPTH))) begin
               put_fifo  = 1'b1;
               issued_in = issued_ff - CNT_W'(1);
               fill_in   = fill_ff + CNT_W'(1);
            end else if ((owned_ff != '0) && (depth_ff < CNT_W'(LIST_DEPTH))) begin
               put_stack = 1'b1;
               issued_in = issued_ff - CNT_W'(1);
               depth_in  = depth_ff + CNT_W'(1);
               owned_in  = owned_ff - CNT_W'(1);
               rels_in   = (rels_ff == '1) ? rels_ff : rels_ff + SCNT_W'(1);
            end else begin
               stat_in = STAT_MISUSE;
            end
         end else begin
            if (is_res && (reserve_ff == '0)) begin
               stat_in = STAT_MISUSE;
            end else if (fill_ff != '0) begin
               src_in    = SRC_FIFO;
               head_in   = head_ff + AW'(1);
               fill_in   = fill_ff - CNT_W'(1);
               issued_in = issued_ff + CNT_W'(1);
            end else if (allowed && ((depth_ff != '0) || (fresh_ff < HEAP_SLOTS))) begin
               if (depth_ff != '0) begin
                  src_in   = SRC_STACK;
                  depth_in = depth_ff - CNT_W'(1);
               end else begin
                  src_in   = SRC_FRESH;
                  slot_in  = fresh_ff[IDX_W-1:0];
                  fresh_in = fresh_ff + CNT_W'(1);
               end
               owned_in  = owned_ff + CNT_W'(1);
               issued_in = issued_ff + CNT_W'(1);
               allocs_in = (allocs_ff == '1) ? allocs_ff : allocs_ff + SCNT_W'(1);
            end else begin
               stat_in = req_data.no_wait ? STAT_REFUSED : STAT_WAIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         fill_ff   <= '0;
         depth_ff  <= '0;
         fresh_ff  <= '0;
         owned_ff  <= '0;
         issued_ff <= '0;
         allocs_ff <= '0;
         rels_ff   <= '0;
         ready_ff  <= 1'b0;
      end else begin
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         depth_ff  <= depth_in;
         fresh_ff  <= fresh_in;
         owned_ff  <= owned_in;
         issued_ff <= issued_in;
         allocs_ff <= allocs_in;
         rels_ff   <= rels_in;
         ready_ff  <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      fillcnt_ff <= fillcnt_in;
      stat_ff    <= stat_in;
      src_ff     <= src_in;
      slot_ff    <= slot_in;
   end

   // Sweep the init fill or append a returned index
   assign fifo_we    = dp_cmd.fill_en || put_fifo;
   assign fifo_waddr = dp_cmd.fill_en ? fillcnt_ff[AW-1:0] : AW'(head_ff + fill_ff[AW-1:0]);
   assign fifo_wdata = dp_cmd.fill_en ? fillcnt_ff[IDX_W-1:0] : req_data.buffer_in;
   assign stack_we   = put_stack;

   bpm_ram #(
      .WIDTH (IDX_W),
      .DEPTH (LIST_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_waddr),
      .wr_data (fifo_wdata),
      .rd_addr (head_ff),
      .rd_data (fifo_rdata)
   );

   bpm_ram #(
      .WIDTH (IDX_W),
      .DEPTH (LIST_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (req_data.buffer_in),
      .rd_addr (AW'(depth_ff[AW-1:0] - AW'(1))),
      .rd_data (stack_rdata)
   );

   // Load the response beat
   always_ff @(posedge clock) begin
      if (dp_cmd.load_rsp) begin
         rsp_ff.status <= stat_ff;
         unique case (src_ff)
            SRC_FIFO:  rsp_ff.buffer_out <= fifo_rdata;
            SRC_STACK: rsp_ff.buffer_out <= stack_rdata;
            SRC_FRESH: rsp_ff.buffer_out <= slot_ff;
            default:   rsp_ff.buffer_out <= '0;
         endcase
         rsp_ff.owned_now    <= owned_ff;
         rsp_ff.issued_now   <= issued_ff;
         rsp_ff.cached_free  <= fill_ff;
         rsp_ff.fresh_allocs <= allocs_ff;
         rsp_ff.releases     <= rels_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ rtl/buffer_pool_manager_top.sv @@
// Channel  | Dir | Ports                               | Accepted when
// request  | in  | req_valid, req_stall, req_data      | req_valid && !req_stall
// response | out | rsp_valid, rsp_stall, rsp_data      | rsp_valid && !rsp_stall
// csr      | in  | csr_wr_en, csr_index, csr_wdata     | csr_wr_en
//
// Get and put accept and decide, then load the response from a registered memory read.
// Init runs a fill sweep that writes one free-list entry a cycle, then loads the response.
// One beat is in flight at a time; a new beat is taken while the previous
// response leaves. Synchronous active-high reset; free-list and stack memories
// are not cleared. rsp_stall holds the response and stalls the request side.
module buffer_pool_manager_top import bpm_pkg::*; #(
   parameter int MAX_BUFFERS = MAX_BUFFERS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata
);

   cmd_type  dp_cmd;
   stat_type dp_stat;

   bpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   bpm_dp #(
      .MAX_BUFFERS (MAX_BUFFERS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

endmodule

@@ rtl/bpm_checker.sv @@
`include "buffer_pool_manager_top_assert.svh"

module bpm_checker import bpm_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input req_type              req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_type              rsp_data,
   input logic                 csr_wr_en,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CNT_W-1:0]     csr_wdata
);

   logic req_acc;
   logic csr_touch;
   logic rsp_held;
   logic short_acc;
   logic pool_even;

   assign req_acc   = req_valid && !req_stall;
   assign csr_touch = csr_wr_en && (csr_index != CSR_TARGET || csr_wdata != '0);
   assign rsp_held  = rsp_valid && rsp_stall;
   assign short_acc = req_acc && (req_data.func != FUNC_INIT);
   assign pool_even = ({1'b0, rsp_data.cached_free} + {1'b0, rsp_data.issued_now}) ==
                      {1'b0, rsp_data.owned_now};

   // A stalled response beat holds
   `BPM_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid && $stable(rsp_data), "stalled response changed")

   // No request is taken while a response waits
   `BPM_ASSERT_ALWAYS(a_no_take_on_full, rsp_held |-> req_stall, "request taken while full")

   // A get or put is answered once the response state has loaded its beat
   `BPM_ASSERT(a_get_put_latency, short_acc |-> ##2 rsp_valid, "get or put response late")

   // Cached plus issued buffers equal owned buffers
   `BPM_ASSERT(a_pool_balance, rsp_valid |-> pool_even || csr_touch, "pool counts out of balance")

endmodule

bind buffer_pool_manager_top bpm_checker u_bpm_checker (.*);
